/* src/sie_pkg.sv */
// Shared types and constants of the sorted information-element store editor.
`default_nettype none

package sie_pkg;

    localparam int STORE_BYTES_DEF = 1024;
    localparam int STAGE_DEPTH     = 257;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_ROOM   = 2'd1,
        STAT_MALFORMED = 2'd2,
        STAT_BEYOND    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ROT,
        CMD_INS,
        CMD_DEL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t  cmd;
        logic [7:0] ins_byte;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SCAN,
        ST_SKIP,
        ST_DEL,
        ST_INS,
        ST_INS_ROT,
        ST_SEEK
    } state_t;

endpackage

`default_nettype wire

/* src/sie_cell.sv */
// One byte cell of the element ring: rotates, opens a gap or closes one.
`default_nettype none

module sie_cell #(
    parameter int IDX = 0,
    parameter int UW  = 11
) (
    input  wire                    aclk,
    input  sie_pkg::cell_ctrl_t    ctrl,
    input  wire  [UW-1:0]          lim,
    input  wire  [7:0]             prev_q,
    input  wire  [7:0]             next_q,
    output logic [7:0]             q
);
    import sie_pkg::*;

    localparam logic [UW:0] POS  = (UW+1)'(IDX);
    localparam logic [UW:0] POS1 = (UW+1)'(IDX + 1);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // lim is the count of stored bytes from the tap cell up to the end of the store.
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CMD_HOLD: data_next = data_reg;
            CMD_ROT:  data_next = next_q;
            CMD_INS: begin
                if (IDX == 0) begin
                    data_next = ctrl.ins_byte;
                end else if (POS <= {1'b0, lim}) begin
                    data_next = prev_q;
                end
            end
            CMD_DEL: begin
                if (POS1 < {1'b0, lim}) begin
                    data_next = next_q;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

/* src/sorted_ie_buffer_editor.sv */
// Top level: request handling, staging buffer, sequencer and the ring of byte cells.
// An add byte that completes no element, a failed add, a read beyond the length and the
// unused op give a valid result from the idle state, through the pending and output registers.
// A read rotates the ring until the byte reaches cell 0.
// Insert and remove rotate to the start, walk the elements (a scan step for each plus one
// rotate per skipped byte), then delete each removed byte, or insert and rotate each new one.
// Reset clears the control state and the length; the byte cells hold no reset value.
`default_nettype none

module sorted_ie_buffer_editor #(
    parameter int STORE_BYTES = sie_pkg::STORE_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // data_byte[7:0], remove_id[15:8], read_index[25:16]
    input  wire  [1:0]  s_tuser,   // op[1:0]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // read_byte[7:0], stored_length[18:8]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import sie_pkg::*;

    localparam int CW   = $clog2(STORE_BYTES);
    localparam int UW   = $clog2(STORE_BYTES + 1);
    localparam int LW   = (UW > 9) ? UW : 9;
    localparam int FW   = LW + 1;
    localparam int CMPW = (UW > 10) ? UW : 10;
    localparam int SW   = $clog2(STAGE_DEPTH);

    state_t             state_reg, state_next;
    logic [CW-1:0]      cur_reg, cur_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [8:0]         stage_cnt_reg, stage_cnt_next;
    logic               failed_reg, failed_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         len_reg, len_next;
    logic [8:0]         elen_reg, elen_next;
    logic [7:0]         rem_id_reg, rem_id_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               remove_reg, remove_next;
    logic [8:0]         cnt_reg, cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_byte_reg, pend_byte_next;
    logic [10:0]        pend_len_reg, pend_len_next;
    status_t            pend_status_reg, pend_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic [10:0]        m_len_reg, m_len_next;
    status_t            m_status_reg, m_status_next;

    logic [7:0]         stage_mem [STAGE_DEPTH];
    logic [7:0]         rdata_reg;
    logic               stage_we;

    cell_ctrl_t         cell_ctrl;
    logic [UW-1:0]      cell_lim;
    logic [7:0]         cell_q [STORE_BYTES];

    logic               s_accept;
    op_t                req_op;
    logic [7:0]         req_data;
    logic [8:0]         cnt_new;
    logic [7:0]         len_new;
    logic               complete;
    logic               res_load;
    logic [7:0]         res_byte;
    status_t            res_status;
    logic [UW-1:0]      avail;
    logic [8:0]         elem_len;
    logic               walk_end;
    logic [CW-1:0]      cur_inc;

    assign s_tready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign req_op   = op_t'(s_tuser);
    assign req_data = s_tdata[7:0];

    assign cur_inc  = (cur_reg == CW'(STORE_BYTES - 1)) ? '0 : cur_reg + 1'b1;
    assign cell_lim = used_reg - UW'(cur_reg);
    assign avail    = cell_lim;
    assign elem_len = 9'd2 + {1'b0, cell_q[1]};
    assign walk_end = (avail < UW'(2)) || (LW'(elem_len) > LW'(avail));

    assign cnt_new  = (stage_cnt_reg < 9'(STAGE_DEPTH)) ? stage_cnt_reg + 9'd1 : stage_cnt_reg;
    assign len_new  = (stage_cnt_reg == 9'd1) ? req_data : len_reg;
    assign complete = (cnt_new >= 9'd2) && (cnt_new == 9'd2 + {1'b0, len_new});
    assign stage_we = s_accept && (req_op == OP_ADD) && !failed_reg
                      && (stage_cnt_reg < 9'(STAGE_DEPTH));

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        used_next       = used_reg;
        stage_cnt_next  = stage_cnt_reg;
        failed_next     = failed_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        elen_next       = elen_reg;
        rem_id_next     = rem_id_reg;
        idx_next        = idx_reg;
        remove_next     = remove_reg;
        cnt_next        = cnt_reg;
        cell_ctrl.cmd      = CMD_HOLD;
        cell_ctrl.ins_byte = rdata_reg;
        res_load        = 1'b0;
        res_byte        = 8'd0;
        res_status      = STAT_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (req_op)
                        OP_ADD: begin
                            if (failed_reg) begin
                                res_load   = 1'b1;
                                res_status = STAT_NO_ROOM;
                                if (s_tlast) begin
                                    failed_next    = 1'b0;
                                    stage_cnt_next = 9'd0;
                                end
                            end else begin
                                if (stage_cnt_reg == 9'd0) begin
                                    id_next = req_data;
                                end
                                len_next = len_new;
                                if (complete) begin
                                    stage_cnt_next = 9'd0;
                                    if (FW'(used_reg) + FW'(cnt_new) > FW'(STORE_BYTES)) begin
                                        // The rest of this stream is ignored until its end.
                                        failed_next = !s_tlast;
                                        res_load    = 1'b1;
                                        res_status  = STAT_NO_ROOM;
                                    end else begin
                                        elen_next   = cnt_new;
                                        remove_next = 1'b0;
                                        state_next  = ST_ALIGN;
                                    end
                                end else begin
                                    stage_cnt_next = s_tlast ? 9'd0 : cnt_new;
                                    res_load       = 1'b1;
                                    if (s_tlast && cnt_new != 9'd0) begin
                                        res_status = STAT_MALFORMED;
                                    end
                                end
                            end
                        end
                        OP_REMOVE: begin
                            rem_id_next = s_tdata[15:8];
                            remove_next = 1'b1;
                            state_next  = ST_ALIGN;
                        end
                        OP_READ: begin
                            if (CMPW'(s_tdata[25:16]) < CMPW'(used_reg)) begin
                                idx_next   = CW'(s_tdata[25:16]);
                                state_next = ST_SEEK;
                            end else begin
                                res_load   = 1'b1;
                                res_status = STAT_BEYOND;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALIGN: begin
                if (cur_reg == '0) begin
                    state_next = ST_SCAN;
                end else begin
                    cell_ctrl.cmd = CMD_ROT;
                    cur_next      = cur_inc;
                end
            end
            ST_SCAN: begin
                if (remove_reg) begin
                    if (walk_end) begin
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else if (cell_q[0] == rem_id_reg) begin
                        cnt_next   = elem_len;
                        state_next = ST_DEL;
                    end else begin
                        cnt_next   = elem_len;
                        state_next = ST_SKIP;
                    end
                end else begin
                    if (walk_end || (cell_q[0] > id_reg)) begin
                        cnt_next   = 9'd0;
                        state_next = ST_INS;
                    end else begin
                        cnt_next   = elem_len;
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                cell_ctrl.cmd = CMD_ROT;
                cur_next      = cur_inc;
                cnt_next      = cnt_reg - 9'd1;
                if (cnt_reg == 9'd1) begin
                    state_next = ST_SCAN;
                end
            end
            ST_DEL: begin
                cell_ctrl.cmd = CMD_DEL;
                used_next     = used_reg - 1'b1;
                cnt_next      = cnt_reg - 9'd1;
                if (cnt_reg == 9'd1) begin
                    state_next = ST_SCAN;
                end
            end
            ST_INS: begin
                cell_ctrl.cmd = CMD_INS;
                used_next     = used_reg + 1'b1;
                state_next    = ST_INS_ROT;
            end
            ST_INS_ROT: begin
                cell_ctrl.cmd = CMD_ROT;
                cur_next      = cur_inc;
                cnt_next      = cnt_reg + 9'd1;
                if (cnt_reg + 9'd1 == elen_reg) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_SEEK: begin
                if (cur_reg == idx_reg) begin
                    res_load   = 1'b1;
                    res_byte   = cell_q[0];
                    state_next = ST_IDLE;
                end else begin
                    cell_ctrl.cmd = CMD_ROT;
                    cur_next      = cur_inc;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // One pending result plus the output register let a request in while a result waits.
    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_byte_next   = pend_byte_reg;
        pend_len_next    = pend_len_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        m_byte_next      = m_byte_reg;
        m_len_next       = m_len_reg;
        m_status_next    = m_status_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pend_valid_reg && (!m_valid_reg || m_tready)) begin
            m_valid_next    = 1'b1;
            m_byte_next     = pend_byte_reg;
            m_len_next      = pend_len_reg;
            m_status_next   = pend_status_reg;
            pend_valid_next = 1'b0;
        end
        if (res_load) begin
            pend_valid_next  = 1'b1;
            pend_byte_next   = res_byte;
            pend_len_next    = 11'(used_next);
            pend_status_next = res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            used_reg       <= '0;
            stage_cnt_reg  <= 9'd0;
            failed_reg     <= 1'b0;
            remove_reg     <= 1'b0;
            cnt_reg        <= 9'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            used_reg       <= used_next;
            stage_cnt_reg  <= stage_cnt_next;
            failed_reg     <= failed_next;
            remove_reg     <= remove_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg          <= id_next;
        len_reg         <= len_next;
        elen_reg        <= elen_next;
        rem_id_reg      <= rem_id_next;
        idx_reg         <= idx_next;
        pend_byte_reg   <= pend_byte_next;
        pend_len_reg    <= pend_len_next;
        pend_status_reg <= pend_status_next;
        m_byte_reg      <= m_byte_next;
        m_len_reg       <= m_len_next;
        m_status_reg    <= m_status_next;
    end

    // Staging buffer: the read data always shows the entry at the current insert count.
    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_mem[stage_cnt_reg[SW-1:0]] <= req_data;
        end
        rdata_reg <= stage_mem[cnt_next[SW-1:0]];
    end

    for (genvar gi = 0; gi < STORE_BYTES; gi++) begin : g_cell
        sie_cell #(
            .IDX (gi),
            .UW  (UW)
        ) u_cell (
            .aclk   (aclk),
            .ctrl   (cell_ctrl),
            .lim    (cell_lim),
            .prev_q (cell_q[(gi + STORE_BYTES - 1) % STORE_BYTES]),
            .next_q (cell_q[(gi + 1) % STORE_BYTES]),
            .q      (cell_q[gi])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_len_reg, m_byte_reg};
    assign m_tuser  = m_status_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(STORE_BYTES))
        else $error("stored length exceeds the store");

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_INS || state_reg == ST_DEL)
        |-> UW'(cur_reg) <= used_reg)
        else $error("tap cell lies beyond the stored bytes during an edit");

    a_stream_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && req_op == OP_ADD && s_tlast)
        |=> (stage_cnt_reg == 9'd0) && !failed_reg)
        else $error("end of add stream left staging state behind");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && m_valid_reg && !m_tready) |=> pend_valid_reg)
        else $error("pending result dropped while output stalled");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> (pend_valid_reg || state_reg != ST_IDLE
        || $past(res_load)))
        else $error("long request finished without a result");

endmodule

`default_nettype wire

/* sim/sorted_ie_buffer_editor_test.sv */
// Self-checking testbench of the sorted information-element store editor.
`timescale 1ns / 1ps

module sorted_ie_buffer_editor_test;

    import sie_pkg::*;

    localparam int STORE = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2000;

    typedef struct {
        bit         sync;
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic [7:0] rid;
        logic [9:0] ridx;
    } request_t;

    typedef struct {
        logic [7:0]  rbyte;
        logic [10:0] length;
        status_t     status;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire  [1:0]  m_tuser;

    sorted_ie_buffer_editor DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    request_t pending[$];
    result_t  expected_results[$];

    // Predicted contents of the editor.
    logic [7:0] ie_store [STORE];
    int         ie_used = 0;
    logic [7:0] staged [STAGE_DEPTH];
    int         staged_count = 0;
    bit         add_aborted = 1'b0;

    int errors = 0;
    int sent_requests = 0;
    int total_requests = 0;
    int got_results = 0;
    int n_no_room = 0, n_malformed = 0, n_beyond = 0, n_reads = 0, n_removes = 0;
    bit s_fire = 1'b0;
    bit stimulus_done = 1'b0;
    bit hold_done = 1'b0;

    function automatic bit insert_staged_element();
        int elen;
        int pos;
        int len;
        elen = staged_count;
        pos = 0;
        if (ie_used + elen > STORE) return 1'b0;
        while (pos + 2 <= ie_used) begin
            len = 2 + ie_store[pos + 1];
            if (pos + len > ie_used || ie_store[pos] > staged[0]) break;
            pos += len;
        end
        for (int i = ie_used - 1; i >= pos; i--) ie_store[i + elen] = ie_store[i];
        for (int i = 0; i < elen; i++) ie_store[pos + i] = staged[i];
        ie_used += elen;
        return 1'b1;
    endfunction

    function automatic void remove_elements(logic [7:0] id);
        int pos;
        int len;
        pos = 0;
        while (pos + 2 <= ie_used) begin
            len = 2 + ie_store[pos + 1];
            if (pos + len > ie_used) break;
            if (ie_store[pos] == id) begin
                for (int i = pos; i < ie_used - len; i++) ie_store[i] = ie_store[i + len];
                ie_used -= len;
            end else begin
                pos += len;
            end
        end
    endfunction

    function automatic result_t predict_result(request_t r);
        result_t res;
        res.rbyte = '0;
        res.status = STAT_OK;
        case (r.op)
            OP_ADD: begin
                if (add_aborted) begin
                    res.status = STAT_NO_ROOM;
                end else begin
                    if (staged_count < STAGE_DEPTH) begin
                        staged[staged_count] = r.data;
                        staged_count++;
                    end
                    if (staged_count >= 2 && staged_count == 2 + staged[1]) begin
                        if (!insert_staged_element()) begin
                            add_aborted = 1'b1;
                            res.status = STAT_NO_ROOM;
                        end
                        staged_count = 0;
                    end
                end
                if (r.last) begin
                    if (!add_aborted && staged_count != 0) res.status = STAT_MALFORMED;
                    staged_count = 0;
                    add_aborted = 1'b0;
                end
            end
            OP_REMOVE: remove_elements(r.rid);
            OP_READ: begin
                if (r.ridx < ie_used) res.rbyte = ie_store[r.ridx];
                else res.status = STAT_BEYOND;
            end
            default: ;
        endcase
        res.length = ie_used[10:0];
        return res;
    endfunction

    function automatic void queue_request(op_t op, logic [7:0] data, logic last,
                                          logic [7:0] rid, logic [9:0] ridx);
        request_t r;
        r.sync = 1'b0;
        r.op = op;
        r.data = data;
        r.last = last;
        r.rid = rid;
        r.ridx = ridx;
        pending.push_back(r);
        total_requests++;
    endfunction

    function automatic void queue_sync();
        request_t r;
        r = '{sync: 1'b1, op: OP_NONE, data: '0, last: 1'b0, rid: '0, ridx: '0};
        pending.push_back(r);
    endfunction

    function automatic void queue_misc();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            queue_request(OP_REMOVE, 8'($urandom), 1'($urandom), 8'($urandom_range(0, 7)),
                          10'($urandom));
        else
            queue_request(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom),
                          10'($urandom_range(0, 300)));
    endfunction

    // One element; when cut is non-negative the stream ends early at that byte.
    function automatic void queue_element(logic [7:0] id, int len, bit final_one, int cut);
        logic [7:0] b;
        bit fin;
        for (int i = 0; i < len + 2; i++) begin
            b = (i == 0) ? id : (i == 1) ? len[7:0] : 8'($urandom);
            fin = (i == cut) || (final_one && i == len + 1);
            queue_request(OP_ADD, b, fin, 8'($urandom), 10'($urandom));
            if (i == cut) return;
            if ($urandom_range(0, 19) == 0) queue_misc();
        end
    endfunction

    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 15);
        if (r < 95) return $urandom_range(16, 80);
        return $urandom_range(81, 255);
    endfunction

    initial begin
        int n;
        int r;
        int cut;
        logic [7:0] id;

        // Directed part: extreme ids and lengths, interleaving, malformed tail,
        // every op, a read beyond the length and a fill that runs out of room.
        queue_element(8'd0, 0, 1'b1, -1);
        queue_element(8'd255, 3, 1'b0, -1);
        queue_request(OP_READ, 8'hFF, 1'b1, 8'hFF, 10'd0);
        queue_request(OP_REMOVE, 8'h00, 1'b0, 8'd9, 10'h3FF);
        queue_element(8'd7, 1, 1'b1, 1);
        queue_request(OP_READ, 8'h00, 1'b0, 8'h00, 10'h3FF);
        queue_request(OP_NONE, 8'hAA, 1'b1, 8'h55, 10'h2AA);
        queue_request(OP_ADD, 8'd5, 1'b1, 8'h00, 10'h000);
        queue_request(OP_REMOVE, 8'hFF, 1'b1, 8'd255, 10'h155);
        queue_request(OP_REMOVE, 8'h00, 1'b0, 8'd0, 10'h000);
        queue_sync();
        for (int i = 0; i < 5; i++) queue_element(8'(i * 40), 255, i == 4, -1);
        queue_request(OP_READ, 8'h00, 1'b0, 8'h00, 10'd1023);
        for (int i = 0; i < 5; i++)
            queue_request(OP_REMOVE, 8'h00, 1'b0, 8'(i * 40), 10'h000);
        queue_sync();

        while (total_requests < 1000) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                n = $urandom_range(1, 4);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
                for (int e = 0; e < n; e++) begin
                    id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
                    r = random_length();
                    if (e == cut) begin
                        queue_element(id, r, 1'b1, $urandom_range(0, r));
                        break;
                    end
                    queue_element(id, r, e == n - 1, -1);
                end
            end else if (r < 70) begin
                queue_request(OP_REMOVE, 8'($urandom), 1'($urandom),
                              ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7))
                                                          : 8'($urandom),
                              10'($urandom));
            end else if (r < 92) begin
                queue_request(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom),
                              ($urandom_range(0, 2) != 0) ? 10'($urandom_range(0, 300))
                                                          : 10'($urandom));
            end else if (r < 95) begin
                queue_request(OP_NONE, 8'($urandom), 1'($urandom), 8'($urandom),
                              10'($urandom));
            end else begin
                queue_request(OP_ADD, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                              10'($urandom));
            end
            if (total_requests > 500 && total_requests < 520) queue_sync();
        end
        // Close any stream left open.
        queue_request(OP_ADD, 8'h00, 1'b1, 8'h00, 10'h000);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: presents queued requests with random bursts of idling.
    int tx_gap = 0;
    always @(negedge aclk) begin
        request_t r;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (pending.size() == 0) begin
                s_tvalid <= 1'b0;
                stimulus_done <= 1'b1;
            end else if (pending[0].sync) begin
                s_tvalid <= 1'b0;
                if (expected_results.size() == 0) void'(pending.pop_front());
            end else begin
                r = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'b0, r.ridx, r.rid, r.data};
                s_tuser <= r.op;
                s_tlast <= r.last;
                if (pending.size() > 150 && $urandom_range(0, 9) == 0)
                    tx_gap <= $urandom_range(1, 8);
            end
        end
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    int rx_gap = 0;
    int hold_left = 0;
    always @(negedge aclk) begin
        if (!hold_done && sent_requests >= 400) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (pending.size() > 150 && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request and checks each result.
    always @(posedge aclk) begin
        request_t r;
        result_t  want;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            r.sync = 1'b0;
            r.op = op_t'(s_tuser);
            r.data = s_tdata[7:0];
            r.rid = s_tdata[15:8];
            r.ridx = s_tdata[25:16];
            r.last = s_tlast;
            if (r.op == OP_REMOVE) n_removes++;
            if (r.op == OP_READ) n_reads++;
            expected_results.push_back(predict_result(r));
            sent_requests++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result read_byte=%0d length=%0d status=%0d",
                         $time, m_tdata[7:0], m_tdata[18:8], m_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.status == STAT_NO_ROOM) n_no_room++;
                if (want.status == STAT_MALFORMED) n_malformed++;
                if (want.status == STAT_BEYOND) n_beyond++;
                if (m_tdata[7:0] !== want.rbyte) begin
                    $display("%0t: read_byte expected %0d got %0d", $time,
                             want.rbyte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[18:8] !== want.length) begin
                    $display("%0t: stored_length expected %0d got %0d", $time,
                             want.length, m_tdata[18:8]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (!(stimulus_done && expected_results.size() == 0) && quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (s_fire || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("sorted_ie_buffer_editor test failed");
            $finish;
        end else begin
            repeat (20) @(posedge aclk);
            if (m_tvalid) begin
                $display("%0t: stray result after the last request", $time);
                errors++;
            end
            $display("Run: %0d requests, %0d results, %0d reads, %0d removes.",
                     sent_requests, got_results, n_reads, n_removes);
            $display("Seen: %0d no-room, %0d malformed, %0d beyond-length; %0d errors.",
                     n_no_room, n_malformed, n_beyond, errors);
            if (errors == 0)
                $display("sorted_ie_buffer_editor test passed");
            else
                $display("sorted_ie_buffer_editor test failed");
            $finish;
        end
    end

endmodule
